// ===== design/tpot_pkg.sv =====
// ----------------------------------------------------------------------------
// tpot_pkg
// shared constants, codes and types of the typed priority order table
// ----------------------------------------------------------------------------
package tpot_pkg;

  // table geometry
  localparam int TABLE_DEPTH   = 16;
  localparam int TYPE_BITS     = 4;
  localparam int PRIORITY_BITS = 8;

  // fixed field widths at the ports
  localparam int MODE_W     = 2;
  localparam int ID_W       = 16;
  localparam int PRIO_IN_W  = 8;
  localparam int DUR_W      = 16;
  localparam int TYPE_IN_W  = 4;
  localparam int OCC_W      = 5;
  localparam int LIMIT_W    = 5;

  // stream word layout
  localparam int S_DATA_W = 48;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = 2;

  // derived widths
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // search tree: first level reduces groups, second level reduces group winners
  localparam int GROUP_SIZE = 4;
  localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_STAGE_LIMIT = 3'd0;
  localparam logic [LIMIT_W-1:0]    STAGE_LIMIT_RESET = 5'd16;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POLL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic [PRIORITY_BITS-1:0] prio;
    logic [DUR_W-1:0]         dur;
    logic [TYPE_BITS-1:0]     kind;
  } tpot_entry_t;

  typedef struct packed {
    logic capture;
    logic search_grp;
    logic search_fin;
    logic update;
  } tpot_cmd_t;

  typedef struct packed {
    logic out_free;
  } tpot_sts_t;

endpackage

// ===== design/tpot_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpot_ctrl
// sequencer: capture, two search levels, then table update and result load
// ----------------------------------------------------------------------------
module tpot_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  tpot_pkg::tpot_sts_t sts,
  output tpot_pkg::tpot_cmd_t cmd
);
  import tpot_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_FINAL,
    ST_UPDATE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_GROUP;
        end
        ST_GROUP: begin
          state <= ST_FINAL;
        end
        ST_FINAL: begin
          // hold the search result until the output register can take the word
          if (sts.out_free) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready       = (state == ST_IDLE);
  assign cmd.capture    = (state == ST_IDLE) && s_tvalid;
  assign cmd.search_grp = (state == ST_GROUP);
  assign cmd.search_fin = (state == ST_FINAL);
  assign cmd.update     = (state == ST_UPDATE);

endmodule

// ===== design/tpot_dp.sv =====
// ----------------------------------------------------------------------------
// tpot_dp
// entry table, two-level registered search tree, compaction and result register
// ----------------------------------------------------------------------------
module tpot_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  tpot_pkg::tpot_cmd_t              cmd,
  output tpot_pkg::tpot_sts_t              sts,
  input  logic [tpot_pkg::LIMIT_W-1:0]     stage_limit,
  input  logic [tpot_pkg::MODE_W-1:0]      mode,
  input  logic [tpot_pkg::ID_W-1:0]        order_id,
  input  logic [tpot_pkg::PRIO_IN_W-1:0]   priority_req,
  input  logic [tpot_pkg::DUR_W-1:0]       duration,
  input  logic [tpot_pkg::TYPE_IN_W-1:0]   order_type,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic                             evicted,
  output logic [tpot_pkg::ID_W-1:0]        out_id,
  output logic [tpot_pkg::PRIO_IN_W-1:0]   out_priority,
  output logic [tpot_pkg::DUR_W-1:0]       out_duration,
  output logic [tpot_pkg::TYPE_IN_W-1:0]   out_type,
  output logic [tpot_pkg::OCC_W-1:0]       occupancy
);
  import tpot_pkg::*;

  // captured request
  logic [MODE_W-1:0] op_mode;
  tpot_entry_t       op_entry;

  // table
  tpot_entry_t       entries [TABLE_DEPTH];
  logic [CNT_W-1:0]  count;

  // per-entry candidates
  logic                     cand_valid [TABLE_DEPTH];
  logic [PRIORITY_BITS-1:0] cand_key   [TABLE_DEPTH];
  logic [CMP_W-1:0]         limit_eff;
  logic                     evict_now;

  // first tree level
  logic                     grp_hit_c [NUM_GROUPS];
  logic [IDX_W-1:0]         grp_idx_c [NUM_GROUPS];
  logic [PRIORITY_BITS-1:0] grp_key_c [NUM_GROUPS];
  logic                     grp_hit   [NUM_GROUPS];
  logic [IDX_W-1:0]         grp_idx   [NUM_GROUPS];
  logic [PRIORITY_BITS-1:0] grp_key   [NUM_GROUPS];

  // second tree level
  logic                     fin_hit_c;
  logic [IDX_W-1:0]         fin_idx_c;
  logic [PRIORITY_BITS-1:0] fin_key_c;
  logic                     best_hit;
  logic [IDX_W-1:0]         best_idx;

  // update
  logic             remove;
  logic [CNT_W-1:0] new_cnt;
  logic             do_append;
  logic [CNT_W-1:0] count_next;
  tpot_entry_t      sel_entry;
  tpot_entry_t      shifted [TABLE_DEPTH];

  always_comb begin
    limit_eff = CMP_W'(stage_limit);
    if (limit_eff == '0) begin
      limit_eff = CMP_W'(1);
    end else if (limit_eff > CMP_W'(TABLE_DEPTH)) begin
      limit_eff = CMP_W'(TABLE_DEPTH);
    end
    evict_now = (op_mode == MODE_ADD) && (CMP_W'(count) >= limit_eff) && (count != '0);
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cand_valid[i] = 1'b0;
      cand_key[i]   = '0;
      if (CNT_W'(i) < count) begin
        case (op_mode)
          MODE_ADD: begin
            // lowest priority wins the eviction search
            cand_valid[i] = evict_now;
            cand_key[i]   = ~entries[i].prio;
          end
          MODE_POLL: begin
            cand_valid[i] = (entries[i].kind == op_entry.kind);
            cand_key[i]   = entries[i].prio;
          end
          MODE_QUERY: begin
            cand_valid[i] = (entries[i].id == op_entry.id);
          end
          default: begin
            cand_valid[i] = 1'b0;
          end
        endcase
      end
    end
  end

  // earlier index kept on equal keys
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_c[g] = 1'b0;
      grp_idx_c[g] = '0;
      grp_key_c[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < TABLE_DEPTH) begin
          if (cand_valid[g * GROUP_SIZE + k] &&
              (!grp_hit_c[g] || cand_key[g * GROUP_SIZE + k] > grp_key_c[g])) begin
            grp_hit_c[g] = 1'b1;
            grp_idx_c[g] = IDX_W'(g * GROUP_SIZE + k);
            grp_key_c[g] = cand_key[g * GROUP_SIZE + k];
          end
        end
      end
    end
  end

  always_comb begin
    fin_hit_c = 1'b0;
    fin_idx_c = '0;
    fin_key_c = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (grp_hit[g] && (!fin_hit_c || grp_key[g] > fin_key_c)) begin
        fin_hit_c = 1'b1;
        fin_idx_c = grp_idx[g];
        fin_key_c = grp_key[g];
      end
    end
  end

  always_comb begin
    remove     = best_hit && ((op_mode == MODE_ADD) || (op_mode == MODE_POLL));
    new_cnt    = count - CNT_W'(remove);
    do_append  = (op_mode == MODE_ADD) && (new_cnt < CNT_W'(TABLE_DEPTH));
    count_next = new_cnt + CNT_W'(do_append);
    sel_entry  = entries[best_idx];
  end

  // each entry's right-hand neighbor, the last one keeps itself
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      shifted[i] = entries[i + 1];
    end
    shifted[TABLE_DEPTH - 1] = entries[TABLE_DEPTH - 1];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode       <= mode;
      op_entry.id   <= order_id;
      op_entry.prio <= PRIORITY_BITS'(priority_req);
      op_entry.dur  <= duration;
      op_entry.kind <= TYPE_BITS'(order_type);
    end
    if (cmd.search_grp) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_hit[g] <= grp_hit_c[g];
        grp_idx[g] <= grp_idx_c[g];
        grp_key[g] <= grp_key_c[g];
      end
    end
    if (cmd.search_fin) begin
      best_hit <= fin_hit_c;
      best_idx <= fin_idx_c;
    end
    if (cmd.update) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (do_append && (new_cnt == CNT_W'(i))) begin
          entries[i] <= op_entry;
        end else if (remove && (CNT_W'(i) >= CNT_W'(best_idx))) begin
          // close the gap left by the removed entry
          entries[i] <= shifted[i];
        end
      end
      found     <= best_hit && ((op_mode == MODE_POLL) || (op_mode == MODE_QUERY));
      evicted   <= best_hit && (op_mode == MODE_ADD);
      occupancy <= OCC_W'(count_next);
      if (remove) begin
        out_id       <= sel_entry.id;
        out_priority <= PRIO_IN_W'(sel_entry.prio);
        out_duration <= sel_entry.dur;
        out_type     <= TYPE_IN_W'(sel_entry.kind);
      end else begin
        out_id       <= '0;
        out_priority <= '0;
        out_duration <= '0;
        out_type     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.update) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== design/typed_priority_order_table.sv =====
// ----------------------------------------------------------------------------
// typed_priority_order_table
// arrival-ordered order table with typed poll, id query and lowest-priority
// eviction once the stage limit is reached
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_*       in   tuser: mode | tdata: order_id, priority_req, duration, order_type
//  m_*       out  tuser: found, evicted | tdata: out_id .. out_type, occupancy
//  apb       in   stage_limit at byte address 0
//
//  each word passes capture, group search, final search and table update in turn,
//  through the two registered levels of the priority search tree and the
//  shift compaction of the table
//  the result register frees the input side; a stalled result holds the
//  sequencer before its update, so no word is lost
//  rst is synchronous: the table empties and stage_limit returns to 16
// ----------------------------------------------------------------------------
module typed_priority_order_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] order_id, [23:16] priority_req, [39:24] duration, [43:40] order_type
  input  logic [tpot_pkg::S_DATA_W-1:0]       s_tdata,
  // [1:0] mode
  input  logic [tpot_pkg::S_USER_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [15:0] out_id, [23:16] out_priority, [39:24] out_duration, [43:40] out_type,
  // [48:44] occupancy
  output logic [tpot_pkg::M_DATA_W-1:0]       m_tdata,
  // [0] found, [1] evicted
  output logic [tpot_pkg::M_USER_W-1:0]       m_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpot_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tpot_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tpot_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import tpot_pkg::*;

  logic [LIMIT_W-1:0]   stage_limit;
  tpot_cmd_t            cmd;
  tpot_sts_t            sts;
  logic                 found;
  logic                 evicted;
  logic [ID_W-1:0]      out_id;
  logic [PRIO_IN_W-1:0] out_priority;
  logic [DUR_W-1:0]     out_duration;
  logic [TYPE_IN_W-1:0] out_type;
  logic [OCC_W-1:0]     occupancy;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_limit <= STAGE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_STAGE_LIMIT)) begin
      stage_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_STAGE_LIMIT) ? APB_DATA_W'(stage_limit) : '0;

  tpot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpot_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .stage_limit  (stage_limit),
    .mode         (s_tuser[MODE_W-1:0]),
    .order_id     (s_tdata[15:0]),
    .priority_req (s_tdata[23:16]),
    .duration     (s_tdata[39:24]),
    .order_type   (s_tdata[43:40]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .found        (found),
    .evicted      (evicted),
    .out_id       (out_id),
    .out_priority (out_priority),
    .out_duration (out_duration),
    .out_type     (out_type),
    .occupancy    (occupancy)
  );

  assign m_tdata = {7'd0, occupancy, out_type, out_duration, out_priority, out_id};
  assign m_tuser = {evicted, found};

`ifndef SYNTHESIS
  // the table never reports more entries than it has
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48:44] <= OCC_W'(TABLE_DEPTH)))
    else $error("occupancy beyond table depth");

  // a word may be a poll or query hit or an eviction, never both
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("found and evicted both set");

  // one word at a time: the input side closes right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a word is in flight");

  // an eviction leaves the table at its former count, never empty
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[48:44] != 5'd0))
    else $error("eviction reported with an empty table");
`endif

endmodule
